// File: hdl/futd_pkg.sv
// Shared types and constants of the font unicode table decoder.
package futd_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned CodeW    = 16;
	localparam int unsigned GlyphW   = 16;
	localparam int unsigned PendingW = 2;

	localparam logic [ByteW-1:0] NEXT_GLYPH_BYTE = 8'hFF;

	typedef struct packed {
		logic [ByteW-1:0] table_byte;
	} byte_item_t;

	typedef struct packed {
		logic [CodeW-1:0]  code_point;
		logic [GlyphW-1:0] glyph_index;
	} code_item_t;

	typedef struct packed {
		logic [GlyphW-1:0]   glyph_count;
		logic [PendingW-1:0] pending_bytes;
		logic [CodeW-1:0]    partial_code;
	} dec_state_t;

	typedef struct packed {
		logic       emit;
		code_item_t item;
		dec_state_t next;
	} dec_result_t;

endpackage

// File: hdl/futd_stream_if.sv
// Valid/ready stream channel with a typed payload.
interface futd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/futd_decode.sv
// Next-state and result logic for one byte of the unicode table.
module futd_decode (
	input  logic [futd_pkg::ByteW-1:0] table_byte,
	input  futd_pkg::dec_state_t       state,
	output futd_pkg::dec_result_t      result
);

	logic [futd_pkg::CodeW-1:0] cont_code;

	assign cont_code = {state.partial_code[futd_pkg::CodeW-7:0], table_byte[5:0]};

	always_comb begin
		result.next             = state;
		result.emit             = 1'b0;
		result.item.code_point  = {{(futd_pkg::CodeW-futd_pkg::ByteW){1'b0}}, table_byte};
		result.item.glyph_index = state.glyph_count;
		if (state.pending_bytes != '0) begin
			// continuation taken blindly, top two bits ignored
			result.next.partial_code  = cont_code;
			result.next.pending_bytes = state.pending_bytes - 2'd1;
			result.emit               = (state.pending_bytes == 2'd1);
			result.item.code_point    = cont_code;
		end else if (table_byte == futd_pkg::NEXT_GLYPH_BYTE) begin
			result.next.glyph_count = state.glyph_count + 16'd1;
		end else if (!table_byte[7]) begin
			result.emit = 1'b1;
		end else if (!table_byte[5]) begin
			result.next.partial_code  = {{(futd_pkg::CodeW-5){1'b0}}, table_byte[4:0]};
			result.next.pending_bytes = 2'd1;
		end else if (!table_byte[4]) begin
			result.next.partial_code  = {{(futd_pkg::CodeW-4){1'b0}}, table_byte[3:0]};
			result.next.pending_bytes = 2'd2;
		end else if (!table_byte[3]) begin
			result.next.partial_code  = {{(futd_pkg::CodeW-3){1'b0}}, table_byte[2:0]};
			result.next.pending_bytes = 2'd3;
		end else begin
			// lead bytes 0xB8 to 0xBF and 0xF8 to 0xFE give code zero
			result.emit            = 1'b1;
			result.item.code_point = '0;
		end
	end

endmodule

// File: hdl/font_unicode_table_decoder_core.sv
// Top level of the font unicode table decoder.
//
// Takes one byte of a bitmap font's unicode table per transfer on table_bytes and
// gives (code_point, glyph_index) pairs on codes. A byte of 0xFF advances the glyph
// number; single bytes, multi-byte sequences and the odd lead bytes decode as the
// table format defines, codes truncated to 16 bits. One byte is accepted every clock
// cycle while the output is not stalled: the whole decode is one combinational step
// between the input register and the result register. The last byte of a result waits
// in byte_s1, its code is registered in item_s2 and then shown on codes. Input stalls
// only while an output result is held by codes.ready low.
module font_unicode_table_decoder_core (
	input  logic                 clk,
	input  logic                 arst_n,
	futd_stream_if.sink          table_bytes,
	futd_stream_if.source        codes
);

	logic                          valid_s1;
	logic [futd_pkg::ByteW-1:0]    byte_s1;
	futd_pkg::dec_state_t          state_q;
	futd_pkg::dec_result_t         dec;
	logic                          valid_s2;
	futd_pkg::code_item_t          item_s2;
	logic                          out_free;
	logic                          fire_s1;

	assign out_free          = !valid_s2 || codes.ready;
	assign fire_s1           = valid_s1 && out_free;
	assign table_bytes.ready = !valid_s1 || out_free;

	futd_decode u_decode (
		.table_byte (byte_s1),
		.state      (state_q),
		.result     (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (table_bytes.ready)
				valid_s1 <= table_bytes.valid;
			if (fire_s1)
				state_q <= dec.next;
			if (out_free)
				valid_s2 <= fire_s1 && dec.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (table_bytes.ready && table_bytes.valid)
			byte_s1 <= table_bytes.data.table_byte;
		if (fire_s1 && dec.emit)
			item_s2 <= dec.item;
	end

	assign codes.valid = valid_s2;
	assign codes.data  = item_s2;

	a_glyph_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(state_q.glyph_count) |->
			state_q.glyph_count == $past(state_q.glyph_count) + 16'd1)
		else $error("glyph counter moved by other than one");

	a_pending_down: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && state_q.pending_bytes != '0) |=>
			state_q.pending_bytes == $past(state_q.pending_bytes) - 2'd1)
		else $error("continuation did not reduce pending count");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!table_bytes.ready |-> (valid_s1 && valid_s2 && !codes.ready))
		else $error("input stalled without a held result");

endmodule

// File: bench/tb_font_unicode_table_decoder_core.sv
`timescale 1ns / 1ps
// Testbench for the font unicode table decoder: directed and random byte streams checked against a predictor.
module tb_font_unicode_table_decoder_core;

	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned RANDOM_BYTES = 725;
	localparam int unsigned PAUSE_EVERY  = 200;

	typedef enum int unsigned {
		SEQ_ASCII,
		SEQ_NEXT_GLYPH,
		SEQ_TWO_BYTE,
		SEQ_THREE_BYTE,
		SEQ_FOUR_BYTE,
		SEQ_ODD_LEAD,
		SEQ_CODE_ZERO,
		SEQ_NOISE
	} seq_kind_e;

	// predicted decoder state and the codes still owed by the block
	class code_scoreboard;
		logic [futd_pkg::GlyphW-1:0]   glyph_count;
		logic [futd_pkg::PendingW-1:0] pending_bytes;
		logic [futd_pkg::CodeW-1:0]    partial_code;
		futd_pkg::code_item_t          expected_codes[$];
		int unsigned                   mismatches;

		function new();
			glyph_count   = '0;
			pending_bytes = '0;
			partial_code  = '0;
			mismatches    = 0;
		endfunction

		function int unsigned outstanding();
			return expected_codes.size();
		endfunction

		function void push_code(logic [futd_pkg::CodeW-1:0] code);
			futd_pkg::code_item_t c;
			c.code_point  = code;
			c.glyph_index = glyph_count;
			expected_codes.push_back(c);
		endfunction

		function void note_byte(futd_pkg::byte_item_t it);
			logic [futd_pkg::ByteW-1:0] b;
			b = it.table_byte;
			if (pending_bytes != '0) begin
				// continuation taken blindly, top bits ignored
				partial_code  = {partial_code[futd_pkg::CodeW-7:0], b[5:0]};
				pending_bytes = pending_bytes - 1'b1;
				if (pending_bytes == '0)
					push_code(partial_code);
			end else if (b == futd_pkg::NEXT_GLYPH_BYTE) begin
				glyph_count = glyph_count + 1'b1;
			end else if (!b[7]) begin
				push_code({8'h00, b});
			end else if (!b[5]) begin
				partial_code  = {11'b0, b[4:0]};
				pending_bytes = 2'd1;
			end else if (!b[4]) begin
				partial_code  = {12'b0, b[3:0]};
				pending_bytes = 2'd2;
			end else if (!b[3]) begin
				partial_code  = {13'b0, b[2:0]};
				pending_bytes = 2'd3;
			end else begin
				push_code('0);
			end
		endfunction

		function void check_code(futd_pkg::code_item_t got);
			futd_pkg::code_item_t want;
			if (expected_codes.size() == 0) begin
				$error("unexpected transfer: code_point %h glyph_index %h",
					got.code_point, got.glyph_index);
				mismatches++;
				return;
			end
			want = expected_codes.pop_front();
			if (got.code_point !== want.code_point) begin
				$error("code_point: expected %h, actual %h", want.code_point, got.code_point);
				mismatches++;
			end
			if (got.glyph_index !== want.glyph_index) begin
				$error("glyph_index: expected %h, actual %h", want.glyph_index, got.glyph_index);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic src_burst;
	logic snk_burst;
	int unsigned bytes_sent;
	code_scoreboard sb;

	futd_stream_if #(.payload_t(futd_pkg::byte_item_t)) table_bytes ();
	futd_stream_if #(.payload_t(futd_pkg::code_item_t)) codes ();

	font_unicode_table_decoder_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.table_bytes (table_bytes),
		.codes       (codes)
	);

	// lead byte classes, blind continuations, odd leads, code 0, long codes
	localparam logic [futd_pkg::ByteW-1:0] DIRECTED [25] = '{
		8'h00, 8'h7F, 8'hFF,
		8'hDF, 8'hFF,
		8'hEF, 8'h80, 8'h3F,
		8'hF7, 8'hFF, 8'hC0, 8'h7F,
		8'h9F, 8'h01,
		8'hA5, 8'h40, 8'h81,
		8'hB2, 8'h3F, 8'h3F, 8'h3F,
		8'hB8, 8'hF8, 8'hFE, 8'hFF
	};

	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic send_byte(input logic [futd_pkg::ByteW-1:0] b);
		int unsigned gap;
		futd_pkg::byte_item_t it;
		it.table_byte = b;
		gap = src_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			table_bytes.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		table_bytes.valid <= 1'b1;
		table_bytes.data  <= it;
		do @(posedge clk); while (!table_bytes.ready);
		sb.note_byte(it);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic drain_codes();
		table_bytes.valid <= 1'b0;
		@(negedge clk);
		while (sb.outstanding() != 0) @(negedge clk);
	endtask

	function automatic logic [futd_pkg::ByteW-1:0] cont_byte();
		if ($urandom_range(0, 7) == 0)
			return futd_pkg::ByteW'($urandom_range(0, 255));
		return 8'h80 | futd_pkg::ByteW'($urandom_range(0, 63));
	endfunction

	task automatic send_sequence();
		seq_kind_e kind;
		int unsigned n;
		kind = seq_kind_e'($urandom_range(0, 7));
		case (kind)
			SEQ_ASCII: begin
				send_byte(futd_pkg::ByteW'($urandom_range(0, 127)));
			end
			SEQ_NEXT_GLYPH: begin
				send_byte(futd_pkg::NEXT_GLYPH_BYTE);
			end
			SEQ_TWO_BYTE: begin
				send_byte(8'hC0 | futd_pkg::ByteW'($urandom_range(0, 31)));
				send_byte(cont_byte());
			end
			SEQ_THREE_BYTE: begin
				send_byte(8'hE0 | futd_pkg::ByteW'($urandom_range(0, 15)));
				repeat (2) send_byte(cont_byte());
			end
			SEQ_FOUR_BYTE: begin
				send_byte(8'hF0 | futd_pkg::ByteW'($urandom_range(0, 7)));
				repeat (3) send_byte(cont_byte());
			end
			SEQ_ODD_LEAD: begin
				send_byte(8'h80 | futd_pkg::ByteW'($urandom_range(0, 63)));
				n = $urandom_range(1, 3);
				repeat (n) send_byte(cont_byte());
			end
			SEQ_CODE_ZERO: begin
				send_byte(futd_pkg::ByteW'($urandom_range(8'hF8, 8'hFE)));
			end
			default: begin
				n = $urandom_range(1, 4);
				repeat (n) send_byte(futd_pkg::ByteW'($urandom_range(0, 255)));
			end
		endcase
	endtask

	// result side: random stalls, with fast stretches
	initial begin
		int unsigned stall;
		codes.ready = 1'b0;
		snk_burst   = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				snk_burst = ~snk_burst;
			stall = snk_burst ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				codes.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			codes.ready <= 1'b1;
			do @(posedge clk); while (!codes.valid);
			sb.check_code(codes.data);
			@(negedge clk);
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((table_bytes.valid && table_bytes.ready) || (codes.valid && codes.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_font_unicode_table_decoder_core: FAIL");
		$finish;
	end

	initial begin
		int unsigned next_pause;
		sb                = new();
		arst_n            = 1'b0;
		src_burst         = 1'b0;
		bytes_sent        = 0;
		table_bytes.valid = 1'b0;
		table_bytes.data  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i]);

		// short stretch streamed back to back
		src_burst = 1'b1;
		send_byte(8'h41);
		send_byte(futd_pkg::NEXT_GLYPH_BYTE);
		send_byte(8'hC3);
		send_byte(8'hA9);
		send_byte(8'h42);
		src_burst = 1'b0;
		drain_codes();

		bytes_sent = 0;
		next_pause = PAUSE_EVERY;
		while (bytes_sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 15) == 0)
				src_burst = ~src_burst;
			send_sequence();
			if (bytes_sent >= next_pause) begin
				drain_codes();
				next_pause += PAUSE_EVERY;
			end
		end

		drain_codes();
		repeat (8) @(posedge clk);
		if (sb.outstanding() != 0) begin
			$error("%0d transfers still expected at end", sb.outstanding());
			sb.mismatches++;
		end
		if (sb.mismatches == 0)
			$display("tb_font_unicode_table_decoder_core: PASS");
		else
			$display("tb_font_unicode_table_decoder_core: FAIL");
		$finish;
	end

endmodule

// File: filelist.f
hdl/futd_pkg.sv
hdl/futd_stream_if.sv
hdl/futd_decode.sv
hdl/font_unicode_table_decoder_core.sv
bench/tb_font_unicode_table_decoder_core.sv
